FILE: rtl/rsdlq_pkg.sv
// ----------------------------------------------------------------------------
// rsdlq_pkg
// Shared types and constants of the rate-shaped drop-tail link queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsdlq_pkg;

  // Queue store geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point formats
  localparam int RATE_FB   = 8;
  localparam int CURSOR_FB = 16;
  localparam int CREDIT_W  = 40;
  localparam int CURSOR_W  = 64;

  // Field widths
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 24;
  localparam int OCC_W   = 6;
  localparam int RATE_W  = 32;

  // Service-time divider: (left << (RATE_FB + CURSOR_FB)) / rate
  localparam int DIV_N_W   = LEN_W + RATE_FB + CURSOR_FB;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Result kinds
  localparam logic [1:0] KIND_DEPART = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_LOSS   = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT     = 3'd4;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_ms;
    logic [LEN_W-1:0]  pkt_length;
    logic [15:0]       random_draw;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TIME_W-1:0]  release_ms;
    logic [LEN_W-1:0]   length_bytes;
    logic [TIME_W-1:0]  arrival_ms;
    logic [OCC_W-1:0]   occupancy_packets;
    logic [BYTES_W-1:0] occupancy_bytes;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic [RATE_W-1:0]  service_rate;
    logic [15:0]        loss_threshold;
    logic [15:0]        prop_delay;
    logic [OCC_W-1:0]   packet_limit;
    logic [BYTES_W-1:0] byte_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/rate_shaped_droptail_link_queue.sv
// ----------------------------------------------------------------------------
// rate_shaped_droptail_link_queue
// Drop-tail packet queue with a byte-credit rate shaper and departure times.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | command, now_ms, pkt_length, random_draw
//  out_    | output    | out_valid / out_ready| kind, release_ms, length, arrival, occupancy
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
//  Each departure an item causes waits on the bit-serial service-time divider
//  (40 steps). Two items queue ahead of the engine; results leave through one
//  output register with one pending result behind it, so out_ready stalls the
//  engine directly, and the input once the two-entry queue fills. Synchronous
//  active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rate_shaped_droptail_link_queue (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_command,
  input  wire logic [31:0]                         in_now_ms,
  input  wire logic [15:0]                         in_pkt_length,
  input  wire logic [15:0]                         in_random_draw,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_kind,
  output logic [31:0]                              out_release_ms,
  output logic [15:0]                              out_length_bytes,
  output logic [31:0]                              out_arrival_ms,
  output logic [5:0]                               out_occupancy_packets,
  output logic [23:0]                              out_occupancy_bytes,
  output logic                                     out_last_result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rsdlq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                         cfg_data
);
  import rsdlq_pkg::*;

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   fq_item;
  logic    fq_valid;
  logic    fq_pop;
  result_t res;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SERVICE_RATE:   cfg_r.service_rate   <= cfg_data;
        CFG_LOSS_THRESHOLD: cfg_r.loss_threshold <= cfg_data[15:0];
        CFG_PROP_DELAY:     cfg_r.prop_delay     <= cfg_data[15:0];
        CFG_PACKET_LIMIT:   cfg_r.packet_limit   <= cfg_data[OCC_W-1:0];
        CFG_BYTE_LIMIT:     cfg_r.byte_limit     <= cfg_data[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.command     = in_command;
  assign in_item.now_ms      = in_now_ms;
  assign in_item.pkt_length  = in_pkt_length;
  assign in_item.random_draw = in_random_draw;

  rsdlq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .fq_valid (fq_valid),
    .fq_pop   (fq_pop),
    .fq_item  (fq_item)
  );

  rsdlq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq_valid  (fq_valid),
    .fq_item   (fq_item),
    .fq_pop    (fq_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind              = res.kind;
  assign out_release_ms        = res.release_ms;
  assign out_length_bytes      = res.length_bytes;
  assign out_arrival_ms        = res.arrival_ms;
  assign out_occupancy_packets = res.occupancy_packets;
  assign out_occupancy_bytes   = res.occupancy_bytes;
  assign out_last_result       = res.last_result;

endmodule

`default_nettype wire

FILE: rtl/rsdlq_front.sv
// ----------------------------------------------------------------------------
// rsdlq_front
// Input side: takes items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsdlq_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rsdlq_pkg::item_t in_item,
  output logic                 fq_valid,
  input  wire logic            fq_pop,
  output rsdlq_pkg::item_t     fq_item
);
  import rsdlq_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign in_ready = (count_r != 2'd2);
  assign fq_valid = (count_r != 2'd0);
  assign fq_item  = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = fq_pop && fq_valid;

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rsdlq_div.sv
// ----------------------------------------------------------------------------
// rsdlq_div
// Restoring divider, one quotient bit per cycle, for packet service time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsdlq_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [rsdlq_pkg::DIV_N_W-1:0]     dividend,
  input  wire logic [rsdlq_pkg::RATE_W-1:0]      divisor,
  output logic                                   done,
  output logic [rsdlq_pkg::DIV_N_W-1:0]          quotient
);
  import rsdlq_pkg::*;

  logic [DIV_N_W-1:0]   quo_r;
  logic [RATE_W-1:0]    rem_r;
  logic [RATE_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [RATE_W:0]      shifted;
  logic                 fits;

  // One restoring step
  assign shifted = {rem_r, quo_r[DIV_N_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], fits};
      rem_r <= fits ? RATE_W'(shifted - {1'b0, dvs_r}) : shifted[RATE_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rsdlq_engine.sv
// ----------------------------------------------------------------------------
// rsdlq_engine
// Back end: credit shaper, packet store, service loop, admission and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsdlq_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fq_valid,
  input  wire rsdlq_pkg::item_t  fq_item,
  output logic                   fq_pop,
  input  wire rsdlq_pkg::cfg_t   cfg,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rsdlq_pkg::result_t     out_res
);
  import rsdlq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SAT   = 4'd3;
  localparam logic [3:0] S_LOOP  = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_CUR   = 4'd7;
  localparam logic [3:0] S_REL   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_CRED  = 4'd10;
  localparam logic [3:0] S_ARR   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  // Control state
  logic [3:0]         state_r;
  logic [3:0]         ret_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   tail_r;
  logic [CNT_W-1:0]   wcnt_r;
  logic [BYTES_W-1:0] wbytes_r;
  logic               isv_r;
  logic [LEN_W-1:0]   left_r;
  logic [CREDIT_W-1:0] credit_r;
  logic [TIME_W-1:0]  last_r;
  logic               pend_v_r;
  logic               out_v_r;

  // Payload state
  item_t              item_r;
  logic [LEN_W-1:0]   slen_r;
  logic [TIME_W-1:0]  sarr_r;
  logic [CREDIT_W-1:0] avail_r;
  logic [CURSOR_W-1:0] cursor_r;
  logic [2*RATE_W-1:0] prod_r;
  result_t            res_r;
  result_t            pend_r;
  result_t            out_r;
  result_t            out_nxt;

  // Packet store
  logic [LEN_W-1:0]   len_mem [QUEUE_DEPTH];
  logic [TIME_W-1:0]  arr_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0]   rd_len_r;
  logic [TIME_W-1:0]  rd_arr_r;

  // Datapath nets
  logic [TIME_W-1:0]   last_eff;
  logic [CREDIT_W-1:0] prod_sat;
  logic [CREDIT_W:0]   avail_sum;
  logic [CREDIT_W-1:0] needed;
  logic                short_credit;
  logic [CREDIT_W-1:0] deficit;
  logic [LEN_W-1:0]    left_ceil;
  logic                div_start;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_q;
  logic [CURSOR_W:0]   cursor_sum;
  logic [CURSOR_W-CURSOR_FB+1:0] rel_sum;
  logic [TIME_W-1:0]   rel_ms;
  logic                queue_empty;
  logic                can_load;
  logic                out_load;
  logic                loss;
  logic                full;
  logic [7:0]          occp_now;
  logic [7:0]          occp_plus;
  logic [BYTES_W:0]    occb_now;
  logic [BYTES_W:0]    occb_plus;
  logic                store_we;

  assign queue_empty = !isv_r && (wcnt_r == '0);
  assign can_load    = !out_v_r || out_ready;
  assign out_load    = pend_v_r && can_load && (state_r == S_PUSH || state_r == S_FIN);
  assign last_eff    = (item_r.now_ms < last_r) ? item_r.now_ms : last_r;

  // Pending result as it enters the output register; last one of the item is marked
  always_comb begin
    out_nxt             = pend_r;
    out_nxt.last_result = (state_r == S_FIN);
  end

  // Credit: saturating product plus carried credit
  assign prod_sat  = (|prod_r[2*RATE_W-1:CREDIT_W]) ? CREDIT_MAX : prod_r[CREDIT_W-1:0];
  assign avail_sum = {1'b0, prod_sat} + {1'b0, credit_r};

  // Head packet demand and partial remainder
  assign needed       = CREDIT_W'({left_r, {RATE_FB{1'b0}}});
  assign short_credit = (avail_r < needed);
  assign deficit      = needed - avail_r;
  assign left_ceil    = LEN_W'((deficit + CREDIT_W'((1 << RATE_FB) - 1)) >> RATE_FB);
  assign div_start    = (state_r == S_LOOP) && (avail_r != '0) && isv_r && !short_credit;

  // Cursor advance and release time
  assign cursor_sum = {1'b0, cursor_r} + (CURSOR_W + 1)'(div_q);
  assign rel_sum    = (CURSOR_W - CURSOR_FB + 2)'(cursor_r[CURSOR_W-1:CURSOR_FB])
                    + (CURSOR_W - CURSOR_FB + 2)'(|cursor_r[CURSOR_FB-1:0])
                    + (CURSOR_W - CURSOR_FB + 2)'(cfg.prop_delay);
  assign rel_ms     = (|rel_sum[CURSOR_W-CURSOR_FB+1:TIME_W]) ? '1 : rel_sum[TIME_W-1:0];

  // Admission checks
  assign occp_now  = 8'(wcnt_r) + 8'(isv_r);
  assign occp_plus = occp_now + 8'd1;
  assign occb_now  = (BYTES_W + 1)'(wbytes_r) + (BYTES_W + 1)'(left_r);
  assign occb_plus = occb_now + (BYTES_W + 1)'(item_r.pkt_length);
  assign loss      = (item_r.random_draw < cfg.loss_threshold);
  assign full      = (wcnt_r >= CNT_W'(QUEUE_DEPTH))
                  || ((cfg.packet_limit != '0) && (occp_plus > 8'(cfg.packet_limit)))
                  || ((cfg.byte_limit != '0) && (occb_plus > (BYTES_W + 1)'(cfg.byte_limit)));
  assign store_we  = (state_r == S_ARR) && item_r.command && !loss && !full;

  assign fq_pop    = (state_r == S_IDLE) && fq_valid;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  rsdlq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({left_r, {(RATE_FB + CURSOR_FB){1'b0}}}),
    .divisor  (cfg.service_rate),
    .done     (div_done),
    .quotient (div_q)
  );

  // Store write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (store_we) begin
      len_mem[tail_r] <= item_r.pkt_length;
      arr_mem[tail_r] <= item_r.now_ms;
    end
    rd_len_r <= len_mem[head_r];
    rd_arr_r <= arr_mem[head_r];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (fq_valid) item_r <= fq_item;
      end
      S_MUL: begin
        prod_r <= (2 * RATE_W)'(item_r.now_ms - last_r) * (2 * RATE_W)'(cfg.service_rate);
      end
      S_SAT: begin
        avail_r  <= avail_sum[CREDIT_W] ? CREDIT_MAX : avail_sum[CREDIT_W-1:0];
        cursor_r <= CURSOR_W'({last_r, {CURSOR_FB{1'b0}}});
      end
      S_LOOP: begin
        if (avail_r != '0 && isv_r && short_credit) avail_r <= '0;
      end
      S_LOAD: begin
        slen_r <= rd_len_r;
        sarr_r <= rd_arr_r;
      end
      S_CUR: begin
        cursor_r <= cursor_sum[CURSOR_W] ? '1 : cursor_sum[CURSOR_W-1:0];
        avail_r  <= avail_r - needed;
      end
      S_REL: begin
        res_r.kind              <= KIND_DEPART;
        res_r.release_ms        <= rel_ms;
        res_r.length_bytes      <= slen_r;
        res_r.arrival_ms        <= sarr_r;
        res_r.occupancy_packets <= OCC_W'(wcnt_r);
        res_r.occupancy_bytes   <= wbytes_r;
        res_r.last_result       <= 1'b0;
      end
      S_ARR: begin
        res_r.release_ms   <= '0;
        res_r.length_bytes <= item_r.pkt_length;
        res_r.arrival_ms   <= item_r.now_ms;
        res_r.last_result  <= 1'b0;
        if (loss) begin
          res_r.kind              <= KIND_LOSS;
          res_r.occupancy_packets <= OCC_W'(occp_now);
          res_r.occupancy_bytes   <= BYTES_W'(occb_now);
        end else if (full) begin
          res_r.kind              <= KIND_FULL;
          res_r.occupancy_packets <= OCC_W'(occp_now);
          res_r.occupancy_bytes   <= BYTES_W'(occb_now);
        end else begin
          res_r.kind              <= KIND_ACCEPT;
          res_r.occupancy_packets <= OCC_W'(occp_plus);
          res_r.occupancy_bytes   <= BYTES_W'(occb_plus);
        end
      end
      S_PUSH: begin
        if (!pend_v_r || can_load) pend_r <= res_r;
      end
      default: begin
      end
    endcase
    // Output register load: pending result moves out
    if (out_load) out_r <= out_nxt;
  end

  // Sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      wcnt_r   <= '0;
      wbytes_r <= '0;
      isv_r    <= 1'b0;
      left_r   <= '0;
      credit_r <= '0;
      last_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (fq_valid) state_r <= S_START;
        end
        S_START: begin
          if (cfg.service_rate == '0) begin
            last_r  <= last_eff;
            state_r <= S_ARR;
          end else if (queue_empty) begin
            credit_r <= '0;
            last_r   <= item_r.now_ms;
            state_r  <= S_ARR;
          end else begin
            last_r  <= last_eff;
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_SAT;
        S_SAT: state_r <= S_LOOP;
        S_LOOP: begin
          if (avail_r == '0) begin
            state_r <= S_CRED;
          end else if (!isv_r) begin
            state_r <= (wcnt_r == '0) ? S_CRED : S_LOAD;
          end else if (short_credit) begin
            left_r  <= left_ceil;
            state_r <= S_CRED;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_LOAD: begin
          isv_r    <= 1'b1;
          left_r   <= rd_len_r;
          head_r   <= (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
          wcnt_r   <= wcnt_r - CNT_W'(1);
          wbytes_r <= wbytes_r - BYTES_W'(rd_len_r);
          state_r  <= S_LOOP;
        end
        S_DIVW: begin
          if (div_done) state_r <= S_CUR;
        end
        S_CUR: begin
          isv_r   <= 1'b0;
          left_r  <= '0;
          state_r <= S_REL;
        end
        S_REL: begin
          ret_r   <= S_LOOP;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!pend_v_r) begin
            pend_v_r <= 1'b1;
            state_r  <= ret_r;
          end else if (can_load) begin
            state_r <= ret_r;
          end
        end
        S_CRED: begin
          credit_r <= queue_empty ? '0 : avail_r;
          last_r   <= item_r.now_ms;
          state_r  <= S_ARR;
        end
        S_ARR: begin
          if (!item_r.command) begin
            state_r <= S_FIN;
          end else begin
            if (store_we) begin
              tail_r   <= (tail_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + IDX_W'(1);
              wcnt_r   <= wcnt_r + CNT_W'(1);
              wbytes_r <= wbytes_r + BYTES_W'(item_r.pkt_length);
            end
            ret_r   <= S_FIN;
            state_r <= S_PUSH;
          end
        end
        S_FIN: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (can_load) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("waiting count above store depth");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (wcnt_r != '0))
    else $error("head load from empty store");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  a_idle_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    !isv_r |-> (left_r == '0))
    else $error("remainder held with no packet in service");

  a_fin_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && pend_v_r && can_load) |=> (out_v_r && out_r.last_result))
    else $error("final result not marked last");
`endif

endmodule

`default_nettype wire
